// ===== rtl/skmnr_pkg.sv =====
// Shared types, constants and helper functions of the split keyboard note router.
`default_nettype none
package skmnr_pkg;

  localparam int unsigned MAX_KEYS    = 37;
  localparam int unsigned Q_DEPTH     = 2;
  localparam int unsigned MAX_RESULTS = 4;
  localparam int unsigned CFG_IDX_W   = 4;
  localparam int unsigned CFG_DATA_W  = 8;

  typedef enum logic [2:0] {
    EV_FORWARD   = 3'd0,
    EV_SYNTH_ON  = 3'd1,
    EV_SYNTH_OFF = 3'd2,
    EV_KEY_REL   = 3'd3,
    EV_KEY_PRESS = 3'd4
  } event_kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GLOBAL_TRANSPOSE   = 4'd0,
    CFG_LOCAL_BASE_KEY     = 4'd1,
    CFG_LOCAL_OCTAVES      = 4'd2,
    CFG_LOCAL_SYNTH_SHIFT  = 4'd3,
    CFG_REMOTE_BASE_KEY    = 4'd4,
    CFG_REMOTE_OCTAVES     = 4'd5,
    CFG_REMOTE_SYNTH_SHIFT = 4'd6,
    CFG_SINK_ENABLES       = 4'd7
  } cfg_idx_e;

  localparam logic [6:0] RST_LOCAL_BASE    = 7'd36;
  localparam logic [1:0] RST_LOCAL_OCT     = 2'd3;
  localparam logic [7:0] RST_LOCAL_SHIFT   = 8'd12;
  localparam logic [6:0] RST_REMOTE_BASE   = 7'd72;
  localparam logic [1:0] RST_REMOTE_OCT    = 2'd3;
  localparam logic [7:0] RST_REMOTE_SHIFT  = 8'd0;

  typedef struct packed {
    logic [7:0] global_transpose;
    logic [6:0] local_base_key;
    logic [1:0] local_octaves;
    logic [7:0] local_synth_shift;
    logic [6:0] remote_base_key;
    logic [1:0] remote_octaves;
    logic [7:0] remote_synth_shift;
    logic [1:0] sink_enables;
  } cfg_t;

  typedef struct packed {
    event_kind_e kind;
    logic        zone;
    logic [8:0]  value;
    logic        fpress;
  } item_t;

  typedef struct packed {
    logic [2:0]                   count;
    item_t [MAX_RESULTS-1:0]      items;
  } bundle_t;

  function automatic logic [6:0] zone_range(input logic [1:0] octaves,
                                            input int unsigned max_keys);
    logic [6:0] r;
    r = 7'({5'd0, octaves} * 7'd12 + 7'd1);
    if (32'(r) > max_keys) begin
      r = 7'(max_keys);
    end
    return r;
  endfunction

  function automatic logic [8:0] sat_note(input logic signed [10:0] v);
    logic [8:0] r;
    if (v < -11'sd128) begin
      r = 9'h180;
    end else if (v > 11'sd255) begin
      r = 9'h0FF;
    end else begin
      r = v[8:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/skmnr_front.sv =====
// Front end: transpose, zone classification, held-note tracking and result bundling.
`default_nettype none
module skmnr_front #(
  parameter int unsigned MaxKeys = skmnr_pkg::MAX_KEYS
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  skmnr_pkg::cfg_t     cfg_i,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  wire  [6:0]          note_i,
  input  wire                 press_i,
  input  wire                 push_ready_i,
  output logic                push_valid_o,
  output skmnr_pkg::bundle_t  push_bundle_o
);
  import skmnr_pkg::*;

  localparam int unsigned KeyW = $clog2(MaxKeys);

  logic [KeyW-1:0] local_held_q, local_held_d;
  logic            local_valid_q, local_valid_d;
  logic [KeyW-1:0] remote_held_q, remote_held_d;
  logic            remote_valid_q, remote_valid_d;

  logic signed [9:0]  t;
  logic signed [9:0]  roff, loff;
  logic               in_r, in_l, take, keys, match, accept;
  logic [6:0]         base;
  logic [7:0]         shift;
  logic [KeyW-1:0]    held, off_k;
  logic               hvalid;
  logic signed [10:0] synth_t, old_note;
  logic [2:0]         n;
  bundle_t            b;

  assign t    = $signed({3'b000, note_i}) + $signed({{2{cfg_i.global_transpose[7]}},
                                                     cfg_i.global_transpose});
  assign roff = t - $signed({3'b000, cfg_i.remote_base_key});
  assign loff = t - $signed({3'b000, cfg_i.local_base_key});
  assign in_r = !roff[9] && (roff[8:0] < {2'b00, zone_range(cfg_i.remote_octaves, MaxKeys)});
  assign in_l = !loff[9] && (loff[8:0] < {2'b00, zone_range(cfg_i.local_octaves, MaxKeys)});
  assign take = in_r || in_l;

  assign base   = in_r ? cfg_i.remote_base_key : cfg_i.local_base_key;
  assign shift  = in_r ? cfg_i.remote_synth_shift : cfg_i.local_synth_shift;
  assign held   = in_r ? remote_held_q : local_held_q;
  assign hvalid = in_r ? remote_valid_q : local_valid_q;
  assign off_k  = in_r ? roff[KeyW-1:0] : loff[KeyW-1:0];
  assign keys   = !in_r && cfg_i.sink_enables[1];
  assign match  = hvalid && (held == off_k);

  assign synth_t  = $signed({t[9], t}) + $signed({{3{shift[7]}}, shift});
  assign old_note = $signed({{(11-KeyW){1'b0}}, held}) + $signed({4'b0000, base})
                  + $signed({{3{shift[7]}}, shift});

  always_comb begin
    b = '0;
    n = 3'd0;
    if (in_r && cfg_i.sink_enables[0]) begin
      b.items[n[1:0]] = '{kind: EV_FORWARD, zone: 1'b1,
                          value: sat_note({t[9], t}), fpress: press_i};
      n = n + 3'd1;
    end
    if (take && !(press_i && match)) begin
      b.items[n[1:0]] = '{kind: press_i ? EV_SYNTH_ON : EV_SYNTH_OFF, zone: in_r,
                          value: sat_note(synth_t), fpress: 1'b0};
      n = n + 3'd1;
      if ((press_i || match) && hvalid) begin
        b.items[n[1:0]] = '{kind: EV_SYNTH_OFF, zone: in_r,
                            value: sat_note(old_note), fpress: 1'b0};
        n = n + 3'd1;
        if (keys) begin
          b.items[n[1:0]] = '{kind: EV_KEY_REL, zone: in_r,
                              value: {{(9-KeyW){1'b0}}, held}, fpress: 1'b0};
          n = n + 3'd1;
        end
      end
      if (press_i && keys) begin
        b.items[n[1:0]] = '{kind: EV_KEY_PRESS, zone: in_r,
                            value: {{(9-KeyW){1'b0}}, off_k}, fpress: 1'b0};
        n = n + 3'd1;
      end
    end
    b.count = n;
  end

  assign in_ready_o    = push_ready_i;
  assign accept        = in_valid_i && push_ready_i;
  assign push_valid_o  = in_valid_i && (b.count != 3'd0);
  assign push_bundle_o = b;

  always_comb begin
    local_held_d   = local_held_q;
    local_valid_d  = local_valid_q;
    remote_held_d  = remote_held_q;
    remote_valid_d = remote_valid_q;
    if (accept && take && !(press_i && match)) begin
      if (in_r) begin
        if (press_i) begin
          remote_held_d  = off_k;
          remote_valid_d = 1'b1;
        end else if (match) begin
          remote_valid_d = 1'b0;
        end
      end else begin
        if (press_i) begin
          local_held_d  = off_k;
          local_valid_d = 1'b1;
        end else if (match) begin
          local_valid_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_held_q   <= '0;
      local_valid_q  <= 1'b0;
      remote_held_q  <= '0;
      remote_valid_q <= 1'b0;
    end else begin
      local_held_q   <= local_held_d;
      local_valid_q  <= local_valid_d;
      remote_held_q  <= remote_held_d;
      remote_valid_q <= remote_valid_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/skmnr_queue.sv =====
// Small FIFO of result bundles between front and back end.
`default_nettype none
module skmnr_queue #(
  parameter int unsigned Depth = skmnr_pkg::Q_DEPTH
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_i,
  input  skmnr_pkg::bundle_t  push_bundle_i,
  output logic                not_full_o,
  input  wire                 pop_i,
  output logic                not_empty_o,
  output skmnr_pkg::bundle_t  head_o
);
  import skmnr_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  bundle_t         mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign not_full_o  = (cnt_q != FullCnt);
  assign not_empty_o = (cnt_q != '0);
  assign do_push     = push_i && not_full_o;
  assign do_pop      = pop_i && not_empty_o;
  assign head_o      = mem_q[rd_q];

  always_comb begin
    wr_d  = do_push ? ((wr_q == LastPtr) ? '0 : wr_q + 1'b1) : wr_q;
    rd_d  = do_pop  ? ((rd_q == LastPtr) ? '0 : rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_bundle_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/skmnr_back.sv =====
// Back end: walk one bundle and send its results one beat at a time.
`default_nettype none
module skmnr_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 head_valid_i,
  input  skmnr_pkg::bundle_t  head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output skmnr_pkg::item_t    item_o,
  output logic                last_o
);
  import skmnr_pkg::*;

  logic [1:0] idx_q, idx_d;
  logic       beat;

  assign out_valid_o = head_valid_i;
  assign item_o      = head_i.items[idx_q];
  assign last_o      = (({1'b0, idx_q} + 3'd1) == head_i.count);
  assign beat        = head_valid_i && out_ready_i;
  assign pop_o       = beat && last_o;

  always_comb begin
    idx_d = idx_q;
    if (beat) begin
      idx_d = last_o ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/split_keyboard_mono_note_router.sv =====
// Split keyboard monophonic note router top level with configuration registers.
//
// Usage: note events enter on s_axis (tdata = note number, tuser = press flag).
// Each event is transposed, routed to the remote or local zone and produces
// zero to four result beats on m_axis, the last one of an event marked by
// tlast. The user writes registers over the cfg port (index, data), always ready,
// only while no event is in flight; the block leaves this to the user. A taken
// event's bundle is registered in the queue, and its first result beat appears
// once that bundle reaches the queue head. Throughput: one result beat per cycle
// while m_axis_tready is high; an event with N results takes N beats, while the
// front end keeps taking events as long as the bundle queue (QueueDepth entries)
// has room. Reset clears registers to their defaults, frees both held notes and
// empties the queue. When the receiver stalls, the current beat holds and
// the queue fills, after which s_axis_tready drops.
`default_nettype none
module split_keyboard_mono_note_router #(
  parameter int unsigned MaxKeys    = skmnr_pkg::MAX_KEYS,
  parameter int unsigned QueueDepth = skmnr_pkg::Q_DEPTH
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire  [7:0]                       s_axis_tdata,  // [6:0] note_number
  input  wire                              s_axis_tuser,  // [0] is_press
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  output logic [15:0]                      m_axis_tdata,  // [8:0] value, [9] forward_press
  output logic [3:0]                       m_axis_tuser,  // [2:0] event_kind, [3] zone
  output logic                             m_axis_tlast,
  input  wire                              cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire  [skmnr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire  [skmnr_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import skmnr_pkg::*;

  cfg_t    cfg_q, cfg_d;
  logic    push_valid, push_ready, q_not_empty, pop;
  bundle_t push_bundle, head;
  item_t   item;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_GLOBAL_TRANSPOSE:   cfg_d.global_transpose   = cfg_data_i;
        CFG_LOCAL_BASE_KEY:     cfg_d.local_base_key     = cfg_data_i[6:0];
        CFG_LOCAL_OCTAVES:      cfg_d.local_octaves      = cfg_data_i[1:0];
        CFG_LOCAL_SYNTH_SHIFT:  cfg_d.local_synth_shift  = cfg_data_i;
        CFG_REMOTE_BASE_KEY:    cfg_d.remote_base_key    = cfg_data_i[6:0];
        CFG_REMOTE_OCTAVES:     cfg_d.remote_octaves     = cfg_data_i[1:0];
        CFG_REMOTE_SYNTH_SHIFT: cfg_d.remote_synth_shift = cfg_data_i;
        CFG_SINK_ENABLES:       cfg_d.sink_enables       = cfg_data_i[1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.global_transpose   <= 8'd0;
      cfg_q.local_base_key     <= RST_LOCAL_BASE;
      cfg_q.local_octaves      <= RST_LOCAL_OCT;
      cfg_q.local_synth_shift  <= RST_LOCAL_SHIFT;
      cfg_q.remote_base_key    <= RST_REMOTE_BASE;
      cfg_q.remote_octaves     <= RST_REMOTE_OCT;
      cfg_q.remote_synth_shift <= RST_REMOTE_SHIFT;
      cfg_q.sink_enables       <= 2'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  skmnr_front #(
    .MaxKeys (MaxKeys)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .note_i        (s_axis_tdata[6:0]),
    .press_i       (s_axis_tuser),
    .push_ready_i  (push_ready),
    .push_valid_o  (push_valid),
    .push_bundle_o (push_bundle)
  );

  skmnr_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push_valid),
    .push_bundle_i (push_bundle),
    .not_full_o    (push_ready),
    .pop_i         (pop),
    .not_empty_o   (q_not_empty),
    .head_o        (head)
  );

  skmnr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_not_empty),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .item_o       (item),
    .last_o       (m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, item.fpress, item.value};
  assign m_axis_tuser = {item.zone, item.kind};

endmodule
`default_nettype wire

// ===== tb/tb_split_keyboard_mono_note_router.sv =====
// Self-checking testbench for the split keyboard monophonic note router.
module tb_split_keyboard_mono_note_router;
  timeunit 1ns;
  timeprecision 1ps;
  import skmnr_pkg::*;

  localparam logic ZONE_REMOTE = 1'b1;
  localparam int STALL_LIMIT   = 3000;
  localparam int RX_HOLD_LEN   = 250;
  localparam int SETTLE_CYCLES = 10;

  typedef struct packed {
    logic [6:0] note;
    logic       press;
  } key_ev_t;

  typedef struct packed {
    event_kind_e kind;
    logic        zone;
    logic [8:0]  value;
    logic        fpress;
    logic        last;
  } router_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [3:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  split_keyboard_mono_note_router dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // router settings and held notes as the block should see them
  int         transpose_all = 0;
  logic [6:0] lo_base  = RST_LOCAL_BASE;
  logic [1:0] lo_oct   = RST_LOCAL_OCT;
  int         lo_shift = 12;
  logic [6:0] re_base  = RST_REMOTE_BASE;
  logic [1:0] re_oct   = RST_REMOTE_OCT;
  int         re_shift = 0;
  logic [1:0] sinks    = 2'b00;
  logic [6:0] lo_held = '0;
  logic       lo_held_vld = 1'b0;
  logic [6:0] re_held = '0;
  logic       re_held_vld = 1'b0;

  key_ev_t      ev_backlog[$];
  router_beat_t beats_due[$];
  logic [6:0]   recent_notes[$];
  key_ev_t      cur_ev;
  int           err_cnt = 0;
  int           src_gap = 0;
  int           stall_left = 0;
  int           idle_cycles = 0;
  logic         tx_gaps_en = 1'b1;
  logic         rx_stalls_en = 1'b1;
  logic         rx_hold_req = 1'b0;

  function automatic logic [8:0] clamp_note(int v);
    if (v < -128) return 9'h180;
    if (v > 255) return 9'h0FF;
    return v[8:0];
  endfunction

  function automatic int zone_keys(logic [1:0] oct);
    int n;
    n = int'(oct) * 12 + 1;
    return (n > MAX_KEYS) ? MAX_KEYS : n;
  endfunction

  function automatic router_beat_t mk_beat(event_kind_e kind, logic zone,
                                           logic [8:0] value, logic fpress);
    router_beat_t b;
    b.kind   = kind;
    b.zone   = zone;
    b.value  = value;
    b.fpress = fpress;
    b.last   = 1'b0;
    return b;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
    case (idx)
      CFG_GLOBAL_TRANSPOSE:   transpose_all = int'($signed(data));
      CFG_LOCAL_BASE_KEY:     lo_base = data[6:0];
      CFG_LOCAL_OCTAVES:      lo_oct = data[1:0];
      CFG_LOCAL_SYNTH_SHIFT:  lo_shift = int'($signed(data));
      CFG_REMOTE_BASE_KEY:    re_base = data[6:0];
      CFG_REMOTE_OCTAVES:     re_oct = data[1:0];
      CFG_REMOTE_SYNTH_SHIFT: re_shift = int'($signed(data));
      CFG_SINK_ENABLES:       sinks = data[1:0];
      default: ;
    endcase
  endfunction

  // Work out the beats one note event produces and update the held notes.
  function automatic void route_note(logic [6:0] note, logic press);
    router_beat_t burst[$];
    int           t;
    int           base;
    int           shift;
    int           off;
    logic         remote;
    logic [6:0]   held;
    logic         vld;
    logic         keys;
    logic         same;
    t = int'(note) + transpose_all;
    if (t - int'(re_base) >= 0 && t - int'(re_base) < zone_keys(re_oct)) begin
      remote = 1'b1;
      base   = int'(re_base);
      shift  = re_shift;
      held   = re_held;
      vld    = re_held_vld;
      keys   = 1'b0;
      if (sinks[0]) begin
        burst = {burst, mk_beat(EV_FORWARD, ZONE_REMOTE, clamp_note(t), press)};
      end
    end else if (t - int'(lo_base) >= 0 && t - int'(lo_base) < zone_keys(lo_oct)) begin
      remote = 1'b0;
      base   = int'(lo_base);
      shift  = lo_shift;
      held   = lo_held;
      vld    = lo_held_vld;
      keys   = sinks[1];
    end else begin
      return;
    end
    off  = t - base;
    same = vld && (int'(held) == off);
    if (!(press && same)) begin
      burst = {burst, mk_beat(press ? EV_SYNTH_ON : EV_SYNTH_OFF, remote,
                              clamp_note(t + shift), 1'b0)};
      if ((press || same) && vld) begin
        burst = {burst, mk_beat(EV_SYNTH_OFF, remote,
                                clamp_note(int'(held) + base + shift), 1'b0)};
        if (keys) begin
          burst = {burst, mk_beat(EV_KEY_REL, remote, {2'b00, held}, 1'b0)};
        end
        vld = 1'b0;
      end
      if (press) begin
        if (keys) begin
          burst = {burst, mk_beat(EV_KEY_PRESS, remote, off[8:0], 1'b0)};
        end
        held = off[6:0];
        vld  = 1'b1;
      end
    end
    if (remote) begin
      re_held     = held;
      re_held_vld = vld;
    end else begin
      lo_held     = held;
      lo_held_vld = vld;
    end
    if (burst.size() > 0) begin
      burst[burst.size()-1].last = 1'b1;
    end
    beats_due = {beats_due, burst};
  endfunction

  function automatic int idle_len();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  // Mostly notes that land in a zone or repeat a recent note, some plain noise.
  function automatic key_ev_t random_event();
    key_ev_t ev;
    int      pick;
    int      t;
    pick = $urandom_range(0, 99);
    if (pick < 30 && recent_notes.size() > 0) begin
      ev.note = recent_notes[$urandom_range(0, recent_notes.size() - 1)];
    end else if (pick < 85) begin
      if ($urandom_range(0, 1)) begin
        t = int'(re_base) + int'($urandom_range(0, zone_keys(re_oct) - 1));
      end else begin
        t = int'(lo_base) + int'($urandom_range(0, zone_keys(lo_oct) - 1));
      end
      t = t - transpose_all;
      ev.note = (t >= 0 && t <= 127) ? t[6:0] : 7'($urandom_range(0, 127));
    end else begin
      ev.note = 7'($urandom_range(0, 127));
    end
    ev.press = ($urandom_range(0, 99) < 55);
    recent_notes = {recent_notes, ev.note};
    if (recent_notes.size() > 4) void'(recent_notes.pop_front());
    return ev;
  endfunction

  task automatic push_ev(logic [6:0] note, logic press);
    key_ev_t ev;
    ev.note  = note;
    ev.press = press;
    ev_backlog = {ev_backlog, ev};
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    apply_reg(idx, data);
  endtask

  task automatic program_regs(logic [7:0] g, logic [7:0] lb, logic [7:0] lo,
                              logic [7:0] ls, logic [7:0] rb, logic [7:0] ro,
                              logic [7:0] rs, logic [7:0] se);
    write_reg(CFG_GLOBAL_TRANSPOSE, g);
    write_reg(CFG_LOCAL_BASE_KEY, lb);
    write_reg(CFG_LOCAL_OCTAVES, lo);
    write_reg(CFG_LOCAL_SYNTH_SHIFT, ls);
    write_reg(CFG_REMOTE_BASE_KEY, rb);
    write_reg(CFG_REMOTE_OCTAVES, ro);
    write_reg(CFG_REMOTE_SYNTH_SHIFT, rs);
    write_reg(CFG_SINK_ENABLES, se);
  endtask

  // Hold until the input side is empty and every expected beat has arrived.
  task automatic settle();
    do @(negedge clk_i); while (ev_backlog.size() > 0 || s_axis_tvalid ||
                                beats_due.size() > 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic random_phase(int n, logic rx_hold, logic mid_pause);
    logic [7:0] g;
    g = ($urandom_range(0, 99) < 60) ? 8'($signed($urandom_range(0, 24)) - 12)
                                     : 8'($urandom_range(0, 255));
    program_regs(g, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)));
    write_reg(CFG_IDX_W'($urandom_range(8, 15)), 8'($urandom_range(0, 255)));
    for (int i = 0; i < n; i++) begin
      ev_backlog = {ev_backlog, random_event()};
      if (mid_pause && i == n / 2) settle();
    end
    if (rx_hold) begin
      @(negedge clk_i);
      rx_hold_req = 1'b1;
    end
    settle();
  endtask

  // note event driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) route_note(cur_ev.note, cur_ev.press);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap = src_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (ev_backlog.size() > 0) begin
          cur_ev = ev_backlog.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {1'b0, cur_ev.note};
          s_axis_tuser  <= cur_ev.press;
          if (tx_gaps_en && $urandom_range(0, 99) < 30) src_gap = idle_len();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result beat monitor and receiver
  always @(posedge clk_i) begin
    router_beat_t act;
    router_beat_t exp_beat;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        act.kind   = event_kind_e'(m_axis_tuser[2:0]);
        act.zone   = m_axis_tuser[3];
        act.value  = m_axis_tdata[8:0];
        act.fpress = m_axis_tdata[9];
        act.last   = m_axis_tlast;
        if (beats_due.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected beat kind=%0d zone=%0d value=%0d fpress=%0d last=%0d",
                   $time, act.kind, act.zone, $signed(act.value), act.fpress, act.last);
        end else begin
          exp_beat = beats_due.pop_front();
          if (act.kind !== exp_beat.kind || act.zone !== exp_beat.zone ||
              act.value !== exp_beat.value || act.fpress !== exp_beat.fpress ||
              act.last !== exp_beat.last) begin
            err_cnt++;
            $display("%0t: beat mismatch expected %0d/%0d/%0d/%0d/%0d, actual %0d/%0d/%0d/%0d/%0d",
                     $time, exp_beat.kind, exp_beat.zone, $signed(exp_beat.value),
                     exp_beat.fpress, exp_beat.last, act.kind, act.zone,
                     $signed(act.value), act.fpress, act.last);
          end
        end
      end
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        stall_left = RX_HOLD_LEN;
      end
      if (stall_left > 0) begin
        stall_left = stall_left - 1;
        m_axis_tready <= 1'b0;
      end else if (rx_stalls_en && $urandom_range(0, 99) < 25) begin
        stall_left = idle_len() - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles = idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // default zones with forwarding and key events on
    program_regs(8'd0, 8'd36, 8'd3, 8'd12, 8'd72, 8'd3, 8'd0, 8'd3);
    push_ev(7'd40, 1'b1);
    push_ev(7'd40, 1'b1);
    push_ev(7'd45, 1'b1);
    push_ev(7'd40, 1'b0);
    push_ev(7'd45, 1'b0);
    push_ev(7'd45, 1'b0);
    push_ev(7'd72, 1'b1);
    push_ev(7'd72, 1'b1);
    push_ev(7'd108, 1'b1);
    push_ev(7'd108, 1'b0);
    push_ev(7'd0, 1'b1);
    push_ev(7'd127, 1'b1);
    push_ev(7'd127, 1'b0);
    push_ev(7'd36, 1'b1);
    push_ev(7'd71, 1'b1);
    push_ev(7'd71, 1'b0);
    settle();

    // extreme settings: saturation at both ends, one-key zone, forward only
    program_regs(8'h40, 8'hFF, 8'h00, 8'h80, 8'hFF, 8'h03, 8'h7F, 8'h01);
    write_reg(CFG_LOCAL_BASE_KEY, 8'h00);
    push_ev(7'd63, 1'b1);
    push_ev(7'd99, 1'b1);
    push_ev(7'd100, 1'b1);
    push_ev(7'd0, 1'b1);
    settle();
    write_reg(CFG_GLOBAL_TRANSPOSE, 8'hC0);
    push_ev(7'd64, 1'b1);
    push_ev(7'd127, 1'b0);
    push_ev(7'd64, 1'b0);
    settle();

    random_phase(25, 1'b0, 1'b0);
    random_phase(25, 1'b1, 1'b0);
    tx_gaps_en   = 1'b0;
    rx_stalls_en = 1'b0;
    random_phase(20, 1'b0, 1'b0);
    tx_gaps_en   = 1'b1;
    rx_stalls_en = 1'b1;
    random_phase(20, 1'b0, 1'b1);

    if (err_cnt == 0 && beats_due.size() == 0 && !m_axis_tvalid) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
